// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/csvm_pkg.sv
package csvm_pkg;

    // Item modes
    localparam logic [2:0] MODE_PROG  = 3'd0;
    localparam logic [2:0] MODE_CTL   = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    // Stop causes
    localparam logic [2:0] CAUSE_BUDGET = 3'd0;
    localparam logic [2:0] CAUSE_HALT   = 3'd1;
    localparam logic [2:0] CAUSE_END    = 3'd2;
    localparam logic [2:0] CAUSE_DIV0   = 3'd3;
    localparam logic [2:0] CAUSE_BADOP  = 3'd4;

    // Config register indexes
    localparam logic CFG_PROG_LEN = 1'b0;
    localparam logic CFG_BUDGET   = 1'b1;

    // Opcodes
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_HALT = 8'h01;
    localparam logic [7:0] OP_LDI  = 8'h10;
    localparam logic [7:0] OP_MOV  = 8'h11;
    localparam logic [7:0] OP_ADD  = 8'h20;
    localparam logic [7:0] OP_SUB  = 8'h21;
    localparam logic [7:0] OP_MUL  = 8'h22;
    localparam logic [7:0] OP_DIV  = 8'h23;
    localparam logic [7:0] OP_AND  = 8'h24;
    localparam logic [7:0] OP_OR   = 8'h25;
    localparam logic [7:0] OP_NOT  = 8'h26;
    localparam logic [7:0] OP_JMP  = 8'h30;
    localparam logic [7:0] OP_JZ   = 8'h31;
    localparam logic [7:0] OP_JNZ  = 8'h32;
    localparam logic [7:0] OP_BTN  = 8'h40;
    localparam logic [7:0] OP_AXIS = 8'h41;
    localparam logic [7:0] OP_OUT  = 8'h42;
    localparam logic [7:0] OP_WAIT = 8'h50;

    localparam logic [8:0] MAX_BUDGET  = 9'd256;
    localparam logic [5:0] BUTTON_BASE = 6'd6;
    localparam logic [7:0] AXIS_COUNT  = 8'd6;
    localparam logic [7:0] BUTTON_COUNT = 8'd32;
    localparam logic [2:0] LAST_FETCH  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_FLAST,
        S_RREAD,
        S_EXEC,
        S_DIVW,
        S_WB,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

endpackage

// File: sv/csvm_progmem.sv
module csvm_progmem #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/csvm_regfile.sv
module csvm_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csvm_pkg::t_rf_wr     i_wr,
    input  logic [4:0]           i_raddr_a,
    input  logic [4:0]           i_raddr_b,
    output logic [31:0]          o_rdata_a,
    output logic [31:0]          o_rdata_b
);
    import csvm_pkg::*;

    logic [31:0] mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_va;
    logic        r_vb;

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_da <= mem[i_raddr_a];
        r_db <= mem[i_raddr_b];
        r_va <= r_vld[i_raddr_a];
        r_vb <= r_vld[i_raddr_b];
    end

    assign o_rdata_a = r_va ? r_da : '0;
    assign o_rdata_b = r_vb ? r_db : '0;
endmodule

// File: sv/csvm_div.sv
module csvm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [32:0] shifted;
    logic [32:0] diff;

    // restoring division on magnitudes, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[31] ? 32'd0 - i_dividend : i_dividend;
            r_den <= i_divisor[31] ? 32'd0 - i_divisor : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? 32'd0 - r_quo : r_quo;
endmodule

// File: sv/controller_script_vm_core.sv
// Gamepad script byte-code machine.
// Input channel (i_in_valid / o_in_ready): one item per transfer. Modes write a
// program byte, set a controller byte (mirrored into the output report), start
// (pc 0, running), stop, or tick. Only a tick of a running machine with a
// nonzero program length yields results: REPORT_BYTES transfers on the output
// channel (o_out_valid / i_out_ready), index order, last_byte on the final one,
// every byte tagged with the tick's stop cause.
// Config channel (i_cfg_valid / o_cfg_ready) is always ready: index 0 program
// length, index 1 instruction budget. Write it only while the block is idle.
// A tick runs each instruction through one end check, five program-memory
// byte reads on the single read port, register read, execute and write back,
// with a divider wait for a nonzero divide; the report then goes out one byte
// per cycle while the receiver keeps i_out_ready high. Items are handled one
// at a time: o_in_ready is low from tick start to the last report transfer.
// A stalled receiver simply holds the current byte. Reset clears registers,
// report bytes, pc and run flag; program memory keeps whatever it held and
// must be written before it is run.
`include "assert_macros.svh"

module controller_script_vm_core #(
    parameter int PROG_DEPTH   = 4096,
    parameter int REPORT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [11:0] i_program_address,
    input  logic [4:0]  i_controller_index,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_output_index,
    output logic [7:0]  o_output_value,
    output logic        o_last_byte,
    output logic [2:0]  o_stop_cause,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import csvm_pkg::*;

    localparam int AW  = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int CW  = 25;   // holds a 24-bit pc plus fetch offset
    localparam int RIW = $clog2(REPORT_BYTES);
    localparam logic [CW-1:0]  DEPTH_C = CW'(PROG_DEPTH);
    localparam logic [5:0]     RB_C    = 6'(REPORT_BYTES);
    localparam logic [RIW-1:0] LAST_IX = RIW'(REPORT_BYTES - 1);

    t_state r_state, n_state;

    logic [12:0]    r_prog_len;
    logic [8:0]     r_budget;
    logic [23:0]    r_pc, n_pc;
    logic           r_run, n_run;
    logic [8:0]     r_done, n_done;
    logic [2:0]     r_fcnt, n_fcnt;
    logic           r_rd_pend, n_rd_pend;
    logic [2:0]     r_rd_idx, n_rd_idx;
    logic           r_rd_ok, n_rd_ok;
    logic [7:0]     r_bytes [5];
    logic [7:0]     n_bytes [5];
    logic [31:0]    r_res, n_res;
    logic           r_wr_en, n_wr_en;
    logic [23:0]    r_next_pc, n_next_pc;
    logic [2:0]     r_cause, n_cause;
    logic [RIW-1:0] r_emit, n_emit;
    logic [7:0]     r_ctl  [REPORT_BYTES];
    logic [7:0]     n_ctl  [REPORT_BYTES];
    logic [7:0]     r_outb [REPORT_BYTES];
    logic [7:0]     n_outb [REPORT_BYTES];

    logic           in_acc;
    logic [8:0]     budget_eff;
    logic [CW-1:0]  prog_end;
    logic           budget_out;
    logic           at_end;
    logic [CW-1:0]  fetch_addr;
    logic           pm_we;
    logic [CW-1:0]  paddr_ext;
    logic [7:0]     pm_rdata;
    t_rf_wr         rf_wr;
    logic [4:0]     rf_ra;
    logic [31:0]    va, vb;
    logic           div_start, div_done;
    logic [31:0]    div_q;
    logic [7:0]     op, o0, o1, o2, o3;
    logic [5:0]     btn_byte;
    logic           out_last;

    // ---------------- shared decode ----------------
    assign op = r_bytes[0];
    assign o0 = r_bytes[1];
    assign o1 = r_bytes[2];
    assign o2 = r_bytes[3];
    assign o3 = r_bytes[4];

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign budget_eff = (r_budget > MAX_BUDGET) ? MAX_BUDGET : r_budget;
    assign prog_end   = (CW'(r_prog_len) < DEPTH_C) ? CW'(r_prog_len) : DEPTH_C;
    assign budget_out = (r_done >= budget_eff);
    assign at_end     = (CW'(r_pc) >= prog_end);
    assign fetch_addr = CW'(r_pc) + CW'(r_fcnt);
    assign paddr_ext  = CW'(i_program_address);
    assign pm_we      = in_acc && (i_mode == MODE_PROG) && (paddr_ext < DEPTH_C);

    // jz/jnz test the register named by the first operand
    assign rf_ra    = ((op == OP_JZ) || (op == OP_JNZ)) ? o0[4:0] : o1[4:0];
    assign btn_byte = BUTTON_BASE + {4'd0, o1[4:3]};

    assign rf_wr.we   = (r_state == S_WB) && r_wr_en;
    assign rf_wr.addr = o0[4:0];
    assign rf_wr.data = r_res;

    assign div_start = (r_state == S_EXEC) && (op == OP_DIV) && (vb != 32'd0);

    // ---------------- storage ----------------
    csvm_progmem #(.AW(AW)) u_prog (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (paddr_ext[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (fetch_addr[AW-1:0]),
        .o_rdata (pm_rdata)
    );

    csvm_regfile u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rf_wr),
        .i_raddr_a (rf_ra),
        .i_raddr_b (o2[4:0]),
        .o_rdata_a (va),
        .o_rdata_b (vb)
    );

    csvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (va),
        .i_divisor  (vb),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_mode == MODE_TICK) && r_run && (r_prog_len != 13'd0)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (budget_out || at_end) ? S_EMIT : S_FETCH;
            end
            S_FETCH: begin
                if (r_fcnt == LAST_FETCH) begin
                    n_state = S_FLAST;
                end
            end
            S_FLAST: n_state = S_RREAD;
            S_RREAD: n_state = S_EXEC;
            S_EXEC: begin
                priority if (op == OP_HALT) begin
                    n_state = S_EMIT;
                end else if (op == OP_DIV) begin
                    n_state = (vb == 32'd0) ? S_EMIT : S_DIVW;
                end else if ((op == OP_NOP) || (op == OP_LDI) || (op == OP_MOV) ||
                             (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
                             (op == OP_AND) || (op == OP_OR) || (op == OP_NOT) ||
                             (op == OP_JMP) || (op == OP_JZ) || (op == OP_JNZ) ||
                             (op == OP_BTN) || (op == OP_AXIS) || (op == OP_OUT) ||
                             (op == OP_WAIT)) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: n_state = S_CHECK;
            S_EMIT: begin
                if (i_out_ready && out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: datapath updates ----------------
    always_comb begin
        n_pc      = r_pc;
        n_run     = r_run;
        n_done    = r_done;
        n_fcnt    = r_fcnt;
        n_rd_pend = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_rd_ok   = r_rd_ok;
        n_bytes   = r_bytes;
        n_res     = r_res;
        n_wr_en   = r_wr_en;
        n_next_pc = r_next_pc;
        n_cause   = r_cause;
        n_emit    = r_emit;
        n_ctl     = r_ctl;
        n_outb    = r_outb;

        // program byte returns in the cycle after its read
        if (r_rd_pend) begin
            n_bytes[r_rd_idx] = r_rd_ok ? pm_rdata : 8'd0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_CTL: begin
                            if ({1'b0, i_controller_index} < RB_C) begin
                                n_ctl[i_controller_index[RIW-1:0]]  = i_data_byte;
                                n_outb[i_controller_index[RIW-1:0]] = i_data_byte;
                            end
                        end
                        MODE_START: begin
                            n_pc  = '0;
                            n_run = 1'b1;
                        end
                        MODE_STOP: n_run = 1'b0;
                        MODE_TICK: begin
                            n_done = '0;
                            n_emit = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                priority if (budget_out) begin
                    n_cause = CAUSE_BUDGET;
                end else if (at_end) begin
                    n_run   = 1'b0;
                    n_cause = CAUSE_END;
                end else begin
                    n_done = r_done + 9'd1;
                    n_fcnt = '0;
                end
            end
            S_FETCH: begin
                n_rd_pend = 1'b1;
                n_rd_idx  = r_fcnt;
                n_rd_ok   = (fetch_addr < prog_end);
                n_fcnt    = r_fcnt + 3'd1;
            end
            S_EXEC: begin
                n_wr_en   = 1'b0;
                n_next_pc = r_pc + 24'd1;
                unique case (op)
                    OP_HALT: begin
                        n_run   = 1'b0;
                        n_cause = CAUSE_HALT;
                    end
                    OP_NOP: ;
                    OP_LDI: begin
                        n_res = {{16{o1[7]}}, o1, o2};
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd4;
                    end
                    OP_MOV: begin
                        n_res = va;
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd3;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR: begin
                        unique case (op)
                            OP_ADD:  n_res = va + vb;
                            OP_SUB:  n_res = va - vb;
                            OP_MUL:  n_res = va * vb;
                            OP_AND:  n_res = va & vb;
                            default: n_res = va | vb;
                        endcase
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd4;
                    end
                    OP_DIV: begin
                        // divide by zero: pc held, still running
                        if (vb == 32'd0) begin
                            n_cause = CAUSE_DIV0;
                        end else begin
                            n_wr_en = 1'b1;
                            n_next_pc = r_pc + 24'd4;
                        end
                    end
                    OP_NOT: begin
                        n_res = ~va;
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd3;
                    end
                    OP_JMP: n_next_pc = {o0, o1, o2};
                    OP_JZ, OP_JNZ: begin
                        if ((op == OP_JZ) == (va == 32'd0)) begin
                            n_next_pc = {o1, o2, o3};
                        end else begin
                            n_next_pc = r_pc + 24'd5;
                        end
                    end
                    OP_BTN: begin
                        n_res = '0;
                        if ((o1 < BUTTON_COUNT) && (btn_byte < RB_C)) begin
                            n_res = {31'd0, r_ctl[btn_byte[RIW-1:0]][o1[2:0]]};
                        end
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd3;
                    end
                    OP_AXIS: begin
                        n_res = (o1 < AXIS_COUNT) ? {24'd0, r_ctl[o1[RIW-1:0]]} : 32'd0;
                        n_wr_en = 1'b1;
                        n_next_pc = r_pc + 24'd3;
                    end
                    OP_OUT: begin
                        if ({1'b0, o0} < {3'd0, RB_C}) begin
                            // clamp signed value to 0..255
                            n_outb[o0[RIW-1:0]] = va[31] ? 8'd0 :
                                ((va > 32'd255) ? 8'd255 : va[7:0]);
                        end
                        n_next_pc = r_pc + 24'd3;
                    end
                    OP_WAIT: n_next_pc = r_pc + 24'd3;
                    default: begin
                        n_run   = 1'b0;
                        n_cause = CAUSE_BADOP;
                    end
                endcase
            end
            S_DIVW: begin
                if (div_done) begin
                    n_res = div_q;
                end
            end
            S_WB: n_pc = r_next_pc;
            S_EMIT: begin
                if (i_out_ready && !out_last) begin
                    n_emit = r_emit + RIW'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prog_len <= '0;
            r_budget   <= MAX_BUDGET;
            r_pc       <= '0;
            r_run      <= 1'b0;
            r_done     <= '0;
            r_fcnt     <= '0;
            r_rd_pend  <= 1'b0;
            r_emit     <= '0;
            r_cause    <= CAUSE_BUDGET;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                r_ctl[i]  <= '0;
                r_outb[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_run     <= n_run;
            r_done    <= n_done;
            r_fcnt    <= n_fcnt;
            r_rd_pend <= n_rd_pend;
            r_emit    <= n_emit;
            r_cause   <= n_cause;
            r_ctl     <= n_ctl;
            r_outb    <= n_outb;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PROG_LEN: r_prog_len <= i_cfg_data;
                    CFG_BUDGET:   r_budget   <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_rd_ok   <= n_rd_ok;
        r_bytes   <= n_bytes;
        r_res     <= n_res;
        r_wr_en   <= n_wr_en;
        r_next_pc <= n_next_pc;
    end

    // ---------------- report output ----------------
    assign out_last       = (r_emit == LAST_IX);
    assign o_out_valid    = (r_state == S_EMIT);
    assign o_output_index = 5'(r_emit);
    assign o_output_value = r_outb[r_emit];
    assign o_last_byte    = out_last;
    assign o_stop_cause   = r_cause;

    // ---------------- checks ----------------
    `ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_last_byte, r_state == S_IDLE,
        "report did not end after last byte")
    `ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid),
        "input taken while report pending")
    `ASSERT_ALWAYS(a_div_owner, i_clk, i_rst_n, !div_done || (r_state == S_DIVW),
        "divider finished outside divide wait")
    `ASSERT_ALWAYS(a_budget_cap, i_clk, i_rst_n, r_done <= MAX_BUDGET,
        "instruction count above cap")

endmodule

// File: tb/csvm_report_checker.sv
`timescale 1ns / 100ps

// Watches the item, report and register channels of the script machine,
// keeps its own copy of the machine state, and checks every report byte.
module csvm_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [11:0] i_program_address,
    input  logic [4:0]  i_controller_index,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_output_index,
    input  logic [7:0]  i_output_value,
    input  logic        i_last_byte,
    input  logic [2:0]  i_stop_cause,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending
);
    import csvm_pkg::*;

    typedef struct packed {
        logic [4:0] index;
        logic [7:0] value;
        logic       last;
        logic [2:0] cause;
    } t_report_byte;

    t_report_byte report_q[$];
    t_report_byte want;

    logic [7:0]  code_mem [4096];
    logic [31:0] regs [32];
    logic [7:0]  pad_bytes [32];
    logic [7:0]  report_bytes [32];
    logic [23:0] pc;
    logic        running;
    logic [12:0] code_len;
    logic [8:0]  budget;
    logic [2:0]  tick_cause;
    int          fail_cnt = 0;

    function automatic logic [31:0] code_end();
        return (code_len < 13'd4096) ? 32'(code_len) : 32'd4096;
    endfunction

    // bytes past the end read as zero
    function automatic logic [7:0] code_byte(logic [31:0] addr);
        return (addr < code_end()) ? code_mem[addr[11:0]] : 8'h00;
    endfunction

    function automatic logic [7:0] clamp_byte(logic [31:0] v);
        if (v[31]) return 8'h00;
        return (v > 32'd255) ? 8'hFF : v[7:0];
    endfunction

    // one instruction; returns 1 when the tick ends, with its cause
    function automatic bit run_instr(output logic [2:0] cause);
        logic [7:0]  op, o0, o1, o2, o3;
        logic [4:0]  d, a, b;
        logic [31:0] va, vb, ma, mb, q;
        logic [23:0] adv;
        bit          zero;
        cause = CAUSE_BUDGET;
        op = code_byte(32'(pc));
        o0 = code_byte(32'(pc) + 1);
        o1 = code_byte(32'(pc) + 2);
        o2 = code_byte(32'(pc) + 3);
        o3 = code_byte(32'(pc) + 4);
        d = o0[4:0];
        a = o1[4:0];
        b = o2[4:0];
        va = regs[a];
        vb = regs[b];
        adv = 24'd1;
        case (op)
            OP_NOP: adv = 24'd1;
            OP_HALT: begin
                running = 1'b0;
                cause = CAUSE_HALT;
                return 1;
            end
            OP_LDI: begin
                regs[d] = {{16{o1[7]}}, o1, o2};
                adv = 24'd4;
            end
            OP_MOV: begin
                regs[d] = va;
                adv = 24'd3;
            end
            OP_ADD: begin regs[d] = va + vb; adv = 24'd4; end
            OP_SUB: begin regs[d] = va - vb; adv = 24'd4; end
            OP_MUL: begin regs[d] = va * vb; adv = 24'd4; end
            OP_DIV: begin
                if (vb == 32'd0) begin
                    cause = CAUSE_DIV0;   // pc stays, still running
                    return 1;
                end
                ma = va[31] ? 32'd0 - va : va;
                mb = vb[31] ? 32'd0 - vb : vb;
                q = ma / mb;
                regs[d] = (va[31] != vb[31]) ? 32'd0 - q : q;
                adv = 24'd4;
            end
            OP_AND: begin regs[d] = va & vb; adv = 24'd4; end
            OP_OR:  begin regs[d] = va | vb; adv = 24'd4; end
            OP_NOT: begin regs[d] = ~va; adv = 24'd3; end
            OP_JMP: begin
                pc = {o0, o1, o2};
                return 0;
            end
            OP_JZ, OP_JNZ: begin
                zero = (regs[d] == 32'd0);
                if ((op == OP_JZ) == zero) begin
                    pc = {o1, o2, o3};
                    return 0;
                end
                adv = 24'd5;
            end
            OP_BTN: begin
                regs[d] = 32'd0;
                if (o1 < 8'd32) regs[d] = 32'(pad_bytes[5'd6 + o1[4:3]][o1[2:0]]);
                adv = 24'd3;
            end
            OP_AXIS: begin
                regs[d] = (o1 < 8'd6) ? 32'(pad_bytes[o1[4:0]]) : 32'd0;
                adv = 24'd3;
            end
            OP_OUT: begin
                if (o0 < 8'd32) report_bytes[o0[4:0]] = clamp_byte(va);
                adv = 24'd3;
            end
            OP_WAIT: adv = 24'd3;
            default: begin
                running = 1'b0;
                cause = CAUSE_BADOP;
                return 1;
            end
        endcase
        pc = pc + adv;
        return 0;
    endfunction

    function automatic logic [2:0] run_tick();
        int          limit;
        int          done;
        logic [2:0]  cause;
        limit = (budget > 9'd256) ? 256 : int'(budget);
        done = 0;
        cause = CAUSE_BUDGET;
        while (done < limit) begin
            done++;
            if (32'(pc) >= code_end()) begin
                running = 1'b0;
                cause = CAUSE_END;
                break;
            end
            if (run_instr(cause)) break;
        end
        return cause;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            report_q.delete();
            for (int k = 0; k < 32; k++) begin
                regs[k] = 32'd0;
                pad_bytes[k] = 8'd0;
                report_bytes[k] = 8'd0;
            end
            pc = 24'd0;
            running = 1'b0;
            code_len = 13'd0;
            budget = 9'd256;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PROG_LEN) code_len = i_cfg_data;
                else budget = i_cfg_data[8:0];
            end
            if (i_in_valid && i_in_ready) begin
                case (i_mode)
                    MODE_PROG: code_mem[i_program_address] = i_data_byte;
                    MODE_CTL: begin
                        pad_bytes[i_controller_index] = i_data_byte;
                        report_bytes[i_controller_index] = i_data_byte;
                    end
                    MODE_START: begin
                        pc = 24'd0;
                        running = 1'b1;
                    end
                    MODE_STOP: running = 1'b0;
                    MODE_TICK: begin
                        if (running && code_len != 13'd0) begin
                            tick_cause = run_tick();
                            for (int k = 0; k < 32; k++)
                                report_q.push_back({5'(k), report_bytes[k], k == 31,
                                                    tick_cause});
                        end
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    $error("report byte %0d with no tick pending", i_output_index);
                    fail_cnt++;
                end else begin
                    want = report_q.pop_front();
                    if (i_output_index !== want.index) begin
                        $error("output_index expected %0d got %0d", want.index,
                               i_output_index);
                        fail_cnt++;
                    end
                    if (i_output_value !== want.value) begin
                        $error("output_value expected %0d got %0d", want.value,
                               i_output_value);
                        fail_cnt++;
                    end
                    if (i_last_byte !== want.last) begin
                        $error("last_byte expected %0d got %0d", want.last, i_last_byte);
                        fail_cnt++;
                    end
                    if (i_stop_cause !== want.cause) begin
                        $error("stop_cause expected %0d got %0d", want.cause,
                               i_stop_cause);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending <= report_q.size();
        o_failures <= fail_cnt;
    end

endmodule

// File: tb/controller_script_vm_core_test.sv
`timescale 1ns / 100ps

// Script machine test: directed programs covering every opcode and each
// corner (div by zero, divide overflow, bad opcode, truncated operands,
// budget hit at program end, length zero, stopped ticks), then random
// programs with random item mixes. Checker module predicts and compares.
module controller_script_vm_core_test;
    import csvm_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;  // > one worst-case tick of divides
    localparam int RANDOM_ITEMS   = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_mode = MODE_STOP;
    logic [11:0] i_program_address = 12'd0;
    logic [4:0]  i_controller_index = 5'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_PROG_LEN;
    logic [12:0] i_cfg_data = 13'd0;
    logic        o_in_ready, o_out_valid, o_last_byte, o_cfg_ready;
    logic [4:0]  o_output_index;
    logic [7:0]  o_output_value;
    logic [2:0]  o_stop_cause;

    int          failures;
    int          pending;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          hold_cnt = 0;
    bit          quiet = 1'b0;    // no idling on either side
    logic [7:0]  code_q[$];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    controller_script_vm_core dut (.*);

    csvm_report_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_mode,
        .i_program_address, .i_controller_index, .i_data_byte,
        .i_out_valid(o_out_valid), .i_out_ready, .i_output_index(o_output_index),
        .i_output_value(o_output_value), .i_last_byte(o_last_byte),
        .i_stop_cause(o_stop_cause), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_failures(failures), .o_pending(pending)
    );

    // Receiver: random stall bursts.
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_cnt <= $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One item transfer; valid stays high into the next item unless a gap comes.
    task automatic send_item(logic [2:0] m, logic [11:0] pa, logic [4:0] ci,
                             logic [7:0] db);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_program_address <= pa;
        i_controller_index <= ci;
        i_data_byte <= db;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold off until every report byte is out, then let the block drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes every byte of code_q, so nothing below the length is unwritten.
    task automatic load_code(int len);
        for (int k = 0; k < code_q.size(); k++)
            send_item(MODE_PROG, 12'(k), 5'($urandom), code_q[k]);
        write_reg(CFG_PROG_LEN, 13'(len));
    endtask

    task automatic send_simple(logic [2:0] m);
        send_item(m, 12'($urandom), 5'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] rand_reg();
        return 8'($urandom);  // only the low 5 bits select
    endfunction

    function automatic void gen_code();
        int          n;
        int          k;
        logic [23:0] target;
        code_q.delete();
        n = $urandom_range(3, 14);
        repeat (n) begin
            k = $urandom_range(0, 19);
            // mostly near targets so loops form; sometimes anywhere
            target = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                     24'($urandom_range(0, 60));
            case (k)
                0: code_q.push_back(OP_NOP);
                1: code_q.push_back(OP_HALT);
                2: code_q = {code_q, OP_LDI, rand_reg(), 8'($urandom), 8'($urandom)};
                3: code_q = {code_q, OP_MOV, rand_reg(), rand_reg()};
                4, 5, 6, 7, 8, 9:
                    code_q = {code_q, OP_ADD + 8'(k - 4), rand_reg(), rand_reg(),
                              rand_reg()};
                10: code_q = {code_q, OP_NOT, rand_reg(), rand_reg()};
                11: code_q = {code_q, OP_JMP, target[23:16], target[15:8], target[7:0]};
                12: code_q = {code_q, OP_JZ, rand_reg(), target[23:16], target[15:8],
                              target[7:0]};
                13: code_q = {code_q, OP_JNZ, rand_reg(), target[23:16], target[15:8],
                              target[7:0]};
                14: code_q = {code_q, OP_BTN, rand_reg(), 8'($urandom_range(0, 40))};
                15: code_q = {code_q, OP_AXIS, rand_reg(), 8'($urandom_range(0, 8))};
                16, 17: code_q = {code_q, OP_OUT, 8'($urandom_range(0, 40)), rand_reg()};
                18: code_q = {code_q, OP_WAIT, 8'($urandom), 8'($urandom)};
                default:
                    code_q.push_back(($urandom_range(0, 3) == 0) ?
                                     8'h60 + 8'($urandom_range(0, 15)) : OP_NOP);
            endcase
        end
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      send_simple(MODE_TICK);
        else if (r < 67) send_simple(MODE_CTL);
        else if (r < 72) send_simple(MODE_STOP);
        else if (r < 80) send_simple(MODE_START);
        else if (r < 85) send_simple(3'($urandom_range(5, 7)));
        else             send_simple(MODE_PROG);
    endtask

    initial begin
        int base;
        int len;
        int r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing runs: stopped tick, then length zero while running.
        send_simple(MODE_TICK);
        send_simple(MODE_START);
        send_simple(MODE_TICK);
        send_simple(3'd5);
        send_simple(3'd6);
        send_simple(3'd7);
        send_item(MODE_CTL, 12'd0, 5'd0, 8'hFF);
        send_item(MODE_CTL, 12'hFFF, 5'd6, 8'hA5);
        send_item(MODE_CTL, 12'd0, 5'd7, 8'h5A);
        send_item(MODE_CTL, 12'd0, 5'd31, 8'h80);
        send_item(MODE_CTL, 12'd0, 5'd2, 8'h00);
        send_item(MODE_PROG, 12'd4095, 5'd31, 8'hFF);

        // Every opcode, clamps, out-of-range button/axis/output, divide overflow.
        code_q = {OP_LDI, 8'h01, 8'h7F, 8'hFF,          // r1 = 32767
                  OP_LDI, 8'h02, 8'h80, 8'h00,          // r2 = -32768
                  OP_LDI, 8'h14, 8'h01, 8'h00,          // r20 = 256
                  OP_MUL, 8'h15, 8'h14, 8'h14,
                  OP_MUL, 8'h16, 8'h15, 8'h02,          // r22 = most negative
                  OP_LDI, 8'h17, 8'hFF, 8'hFF,          // r23 = -1
                  OP_DIV, 8'h18, 8'h16, 8'h17,          // overflow case
                  OP_ADD, 8'h03, 8'h01, 8'h02,
                  OP_SUB, 8'h04, 8'h02, 8'h01,
                  OP_DIV, 8'h06, 8'h02, 8'hE1,          // negative / positive
                  OP_AND, 8'h07, 8'h01, 8'h02,
                  OP_OR,  8'h08, 8'h01, 8'h02,
                  OP_NOT, 8'h09, 8'h01,
                  OP_MOV, 8'hEA, 8'h02,
                  OP_BTN, 8'h0B, 8'h08,
                  OP_BTN, 8'h0C, 8'd40,
                  OP_AXIS, 8'h0D, 8'h00,
                  OP_AXIS, 8'h0E, 8'h07,
                  OP_OUT, 8'd0, 8'h01,
                  OP_OUT, 8'd1, 8'h02,
                  OP_OUT, 8'd31, 8'h0D,
                  OP_OUT, 8'd40, 8'h01,
                  OP_WAIT, 8'hFF, 8'hFF,
                  OP_NOP};
        len = code_q.size();
        // taken JZ on r0 skips a halt
        code_q = {code_q, OP_JZ, 8'h00, 8'h00, 8'h00, 8'(len + 6), OP_HALT};
        len = code_q.size();
        code_q = {code_q, OP_JNZ, 8'h01, 8'h00, 8'h00, 8'(len + 6), OP_HALT};
        code_q = {code_q, OP_JZ, 8'h01, 8'hFF, 8'hFF, 8'hFF};     // not taken
        len = code_q.size();
        code_q = {code_q, OP_JMP, 8'h00, 8'h00, 8'(len + 5), OP_HALT, OP_HALT};
        load_code(code_q.size());
        send_simple(MODE_START);
        send_simple(MODE_TICK);
        // full length; halts well before the unwritten bytes
        write_reg(CFG_PROG_LEN, 13'd4096);
        send_simple(MODE_START);
        send_simple(MODE_TICK);

        // Divide by zero twice (pc kept), then stop and a stopped tick.
        code_q = {OP_LDI, 8'h01, 8'h00, 8'h05, OP_DIV, 8'h02, 8'h01, 8'h00};
        load_code(code_q.size());
        send_simple(MODE_START);
        send_simple(MODE_TICK);
        send_simple(MODE_TICK);
        send_simple(MODE_STOP);
        send_simple(MODE_TICK);

        // Truncated operands, budget used up exactly at the end, then end of program.
        code_q = {OP_NOP, OP_NOP, OP_LDI, 8'h05, 8'h12, 8'h34};
        load_code(5);
        write_reg(CFG_BUDGET, 13'd3);
        send_simple(MODE_START);
        send_simple(MODE_TICK);
        send_simple(MODE_TICK);
        send_simple(MODE_TICK);
        // budget zero, then budget above the maximum
        write_reg(CFG_BUDGET, 13'd0);
        send_simple(MODE_START);
        send_simple(MODE_TICK);
        write_reg(CFG_BUDGET, 13'd511);
        send_simple(MODE_TICK);

        // Unknown opcode
        code_q = {8'h77};
        load_code(1);
        write_reg(CFG_BUDGET, 13'd1);
        send_simple(MODE_START);
        send_simple(MODE_TICK);

        // Random programs with random item mixes; the tail runs without idling.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            gen_code();
            len = code_q.size() - $urandom_range(0, 2);
            if (len < 1) len = 1;
            load_code(len);
            r = $urandom_range(0, 3);
            write_reg(CFG_BUDGET, (r == 0) ? 13'd1 : (r == 1) ? 13'd256 :
                                  (r == 2) ? 13'($urandom_range(1, 64)) :
                                             13'($urandom_range(1, 256)));
            send_simple(MODE_START);
            repeat ($urandom_range(8, 20)) begin
                random_item();
                if (items_sent - base > RANDOM_ITEMS - 40) quiet = 1'b1;
            end
        end

        settle();
        if (failures == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
